// File: design/uav_pkg.sv
// ----------------------------------------------------------------------------
// uav_pkg
// Shared types, codes and helpers for the ustar archive validator.
// ----------------------------------------------------------------------------
`default_nettype none

package uav_pkg;

  localparam int BlockBytes     = 512;
  localparam int NameFieldBytes = 100;
  localparam int SizeFieldBytes = 12;
  localparam int SumAt          = 148;
  localparam int SumEnd         = 156;
  localparam int TypeAt         = 156;
  localparam int MagicAt        = 257;
  localparam int SizeAt         = 124;
  localparam int FifoDepth      = 4;
  localparam int FifoPtrW       = $clog2(FifoDepth);

  localparam logic [23:0] MAX_MANIFEST_RESET = 24'd65536;
  localparam logic [19:0] MAX_MEMBERS_RESET  = 20'd1000000;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_MANIFEST = 2'd0;
  localparam logic [1:0] CFG_MAX_MEMBERS  = 2'd1;

  // result kinds
  localparam logic [1:0] KIND_MBYTE  = 2'd0;
  localparam logic [1:0] KIND_MEMBER = 2'd1;
  localparam logic [1:0] KIND_VALID  = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // error codes
  localparam logic [4:0] ERR_TRUNC_HDR    = 5'd0;
  localparam logic [4:0] ERR_NOT_USTAR    = 5'd1;
  localparam logic [4:0] ERR_CHECKSUM     = 5'd2;
  localparam logic [4:0] ERR_EMPTY_NAME   = 5'd3;
  localparam logic [4:0] ERR_BAD_SIZE     = 5'd4;
  localparam logic [4:0] ERR_EXTENSION    = 5'd5;
  localparam logic [4:0] ERR_BAD_PATH     = 5'd6;
  localparam logic [4:0] ERR_LINK         = 5'd7;
  localparam logic [4:0] ERR_BAD_TYPE     = 5'd8;
  localparam logic [4:0] ERR_MF_IRREGULAR = 5'd9;
  localparam logic [4:0] ERR_DUPLICATE    = 5'd10;
  localparam logic [4:0] ERR_MF_SIZE      = 5'd11;
  localparam logic [4:0] ERR_TRUNC_MF     = 5'd12;
  localparam logic [4:0] ERR_TRUNC_MEMBER = 5'd13;
  localparam logic [4:0] ERR_TOO_MANY     = 5'd14;
  localparam logic [4:0] ERR_NO_END2      = 5'd15;
  localparam logic [4:0] ERR_NO_MANIFEST  = 5'd16;

  // octal field parse states
  localparam logic [1:0] OCT_LEAD = 2'd0;
  localparam logic [1:0] OCT_DIG  = 2'd1;
  localparam logic [1:0] OCT_DONE = 2'd2;
  localparam logic [1:0] OCT_BAD  = 2'd3;

  // path matcher states of note
  localparam logic [4:0] PM_START   = 5'd0;
  localparam logic [4:0] PM_META    = 5'd1;
  localparam logic [4:0] PM_META4   = 5'd4;
  localparam logic [4:0] PM_META5   = 5'd5;
  localparam logic [4:0] PM_MANI    = 5'd13;
  localparam logic [4:0] PM_PAY     = 5'd14;
  localparam logic [4:0] PM_PAY_END = 5'd20;
  localparam logic [4:0] PM_PAY_IN  = 5'd21;
  localparam logic [4:0] PM_PAY_ANY = 5'd22;
  localparam logic [4:0] PM_MANI_SL = 5'd23;
  localparam logic [4:0] PM_DEAD    = 5'd31;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_DATA   = 3'd1,
    PH_PAD    = 3'd2,
    PH_END2   = 3'd3,
    PH_DRAIN  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [4:0]  error_code;
    logic [7:0]  manifest_byte;
    logic [35:0] member_size;
    logic        member_kind;
    logic        is_manifest;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [35:0] val;
  } oct_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [4:0] err, logic [7:0] mb,
                                  logic [35:0] sz, logic mk, logic im);
    res_t r;
    r.out_kind      = kind;
    r.error_code    = err;
    r.manifest_byte = mb;
    r.member_size   = sz;
    r.member_kind   = mk;
    r.is_manifest   = im;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  function automatic oct_t octal_step(logic [1:0] st, logic [35:0] val, logic [7:0] c);
    oct_t o;
    logic dig;
    logic sp;
    dig   = (c >= 8'h30) && (c <= 8'h37);
    sp    = (c == 8'h20) || (c == 8'h00);
    o.st  = st;
    o.val = val;
    unique case (st)
      OCT_LEAD: begin
        if (sp) begin
        end else if (dig) begin
          o.st  = OCT_DIG;
          o.val = {33'd0, c[2:0]};
        end else begin
          o.st = OCT_BAD;
        end
      end
      OCT_DIG: begin
        if (sp) begin
          o.st = OCT_DONE;
        end else if (dig) begin
          o.val = {val[32:0], c[2:0]};
        end else begin
          o.st = OCT_BAD;
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  // expected character at matcher state s
  function automatic logic [7:0] path_char(logic [4:0] s);
    logic [7:0] ch;
    unique case (s)
      5'd1:  ch = "E";
      5'd2:  ch = "T";
      5'd3:  ch = "A";
      5'd4:  ch = "/";
      5'd5:  ch = "m";
      5'd6:  ch = "a";
      5'd7:  ch = "n";
      5'd8:  ch = "i";
      5'd9:  ch = "f";
      5'd10: ch = "e";
      5'd11: ch = "s";
      5'd12: ch = "t";
      5'd14: ch = "a";
      5'd15: ch = "y";
      5'd16: ch = "l";
      5'd17: ch = "o";
      5'd18: ch = "a";
      5'd19: ch = "d";
      5'd20: ch = "/";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [4:0] path_next(logic [4:0] s, logic [7:0] c);
    logic [4:0] nx;
    if (s == PM_START) begin
      nx = (c == "M") ? PM_META : ((c == "p") ? PM_PAY : PM_DEAD);
    end else if ((s >= 5'd1 && s <= 5'd12) || (s >= PM_PAY && s <= PM_PAY_END)) begin
      nx = (c == path_char(s)) ? s + 5'd1 : PM_DEAD;
    end else if (s == PM_MANI) begin
      nx = (c == "/") ? PM_MANI_SL : PM_DEAD;
    end else if (s == PM_PAY_IN || s == PM_PAY_ANY) begin
      nx = PM_PAY_ANY;
    end else begin
      nx = PM_DEAD;
    end
    return nx;
  endfunction

endpackage

`default_nettype wire

// File: design/ustar_archive_validator_top.sv
// ----------------------------------------------------------------------------
// ustar_archive_validator_top
// Streams a tar archive byte by byte, checks every ustar header and gives
// one verdict per archive, passing the manifest bytes out on the way.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  in       | in_valid / in_ready    | data_byte, end_of_stream
//  out      | out_valid / out_ready  | out_kind, error_code, manifest_byte,
//           |                        | member_size, member_kind, is_manifest,
//           |                        | last_of_run
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One archive byte per cycle while in_ready is high; every byte's work is done
//  in the cycle it is taken, its results land in a four-entry result queue.
//  A byte gives at most two results; in_ready drops only when the queue has
//  fewer than two free entries, so stalls come from out_ready alone.
//  Results pass through the registered result queue before they appear on out.
//  Synchronous reset; no clearing pass, the block takes beats straight after.
//  cfg_ready is always high; registers beyond the list are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module ustar_archive_validator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // archive bytes
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_stream,
  // results
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [4:0]       error_code,
  output logic [7:0]       manifest_byte,
  output logic [35:0]      member_size,
  output logic             member_kind,
  output logic             is_manifest,
  output logic             last_of_run,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  import uav_pkg::*;

  logic [23:0] max_manifest_bytes;
  logic [19:0] max_members;
  logic        accept;
  logic        room;
  push_t       push;
  res_t        head;

  assign cfg_ready = 1'b1;
  assign in_ready  = room;
  assign accept    = in_valid && in_ready;

  // configuration registers: the user must write them only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      max_manifest_bytes <= MAX_MANIFEST_RESET;
      max_members        <= MAX_MEMBERS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MAX_MANIFEST) max_manifest_bytes <= cfg_data;
      if (cfg_index == CFG_MAX_MEMBERS)  max_members        <= cfg_data[19:0];
    end
  end

  uav_core u_core (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .data_byte          (data_byte),
    .end_of_stream      (end_of_stream),
    .max_manifest_bytes (max_manifest_bytes),
    .max_members        (max_members),
    .push               (push)
  );

  uav_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind      = head.out_kind;
  assign error_code    = head.error_code;
  assign manifest_byte = head.manifest_byte;
  assign member_size   = head.member_size;
  assign member_kind   = head.member_kind;
  assign is_manifest   = head.is_manifest;
  assign last_of_run   = head.last_of_run;

endmodule

`default_nettype wire

// File: design/uav_core.sv
// ----------------------------------------------------------------------------
// uav_core
// Per-byte archive state: header checks, data/pad skipping with manifest bytes passed out, end blocks.
// ----------------------------------------------------------------------------
`default_nettype none

module uav_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic [7:0]   data_byte,
  input  wire logic         end_of_stream,
  input  wire logic [23:0]  max_manifest_bytes,
  input  wire logic [19:0]  max_members,
  output uav_pkg::push_t    push
);
  import uav_pkg::*;

  typedef struct packed {
    phase_t      phase;
    logic [8:0]  block_offset;
    logic [16:0] byte_sum;
    logic        all_zero;
    logic        magic_ok;
    logic [23:0] stored_sum;
    logic [1:0]  sum_st;
    logic [35:0] size_value;
    logic [1:0]  size_st;
    logic [7:0]  type_byte;
    logic [6:0]  name_length;
    logic [4:0]  pm;
    logic [2:0]  comp;
    logic        unsafe;
    logic [7:0]  prev_char;
    logic [35:0] remaining;
    logic [19:0] members_done;
    logic        manifest_seen;
    logic        in_manifest;
  } st_t;

  st_t st;
  st_t st_next;

  function automatic st_t start_header(st_t s);
    st_t o;
    o              = s;
    o.phase        = PH_HEADER;
    o.block_offset = '0;
    o.byte_sum     = '0;
    o.all_zero     = 1'b1;
    o.magic_ok     = 1'b1;
    o.stored_sum   = '0;
    o.sum_st       = OCT_LEAD;
    o.size_value   = '0;
    o.size_st      = OCT_LEAD;
    o.type_byte    = '0;
    o.name_length  = '0;
    o.pm           = PM_START;
    o.comp         = '0;
    o.unsafe       = 1'b0;
    o.prev_char    = '0;
    return o;
  endfunction

  function automatic st_t clear_all(st_t s);
    st_t o;
    o               = start_header(s);
    o.remaining     = '0;
    o.members_done  = '0;
    o.manifest_seen = 1'b0;
    o.in_manifest   = 1'b0;
    return o;
  endfunction

  always_comb begin
    st_t         s;
    res_t        res [2];
    logic [1:0]  n;
    logic        verdict;
    logic        eos;
    logic [7:0]  c;
    logic [8:0]  off;
    logic        done;
    logic [7:0]  t;
    logic        mani;
    logic [8:0]  pad;
    logic [20:0] cnt;
    logic        do_complete;
    oct_t        o;
    logic        path_ok;

    s           = st;
    res[0]      = mk_res(KIND_MBYTE, ERR_TRUNC_HDR, 8'd0, 36'd0, 1'b0, 1'b0);
    res[1]      = res[0];
    n           = 2'd0;
    verdict     = 1'b0;
    eos         = end_of_stream;
    c           = data_byte;
    off         = st.block_offset;
    done        = 1'b0;
    t           = 8'd0;
    mani        = 1'b0;
    pad         = 9'd0;
    cnt         = 21'd0;
    do_complete = 1'b0;
    o           = '0;
    path_ok     = 1'b0;

    unique case (st.phase)
      PH_DRAIN: begin
        if (eos) s = clear_all(st);
      end

      PH_HEADER: begin
        if (c != 8'd0) s.all_zero = 1'b0;
        s.byte_sum = s.byte_sum +
          ((off >= 9'(SumAt) && off < 9'(SumEnd)) ? 17'h20 : {9'd0, c});
        if (off >= 9'(MagicAt) && off < 9'(MagicAt + 5)) begin
          unique case (off - 9'(MagicAt))
            9'd0: if (c != "u") s.magic_ok = 1'b0;
            9'd1: if (c != "s") s.magic_ok = 1'b0;
            9'd2: if (c != "t") s.magic_ok = 1'b0;
            9'd3: if (c != "a") s.magic_ok = 1'b0;
            default: if (c != "r") s.magic_ok = 1'b0;
          endcase
        end else if (off == 9'(MagicAt + 5) && c != 8'd0) begin
          s.magic_ok = 1'b0;
        end
        if (off >= 9'(SumAt) && off < 9'(SumEnd)) begin
          o            = octal_step(s.sum_st, {12'd0, s.stored_sum}, c);
          s.sum_st     = o.st;
          s.stored_sum = o.val[23:0];
        end
        if (off >= 9'(SizeAt) && off < 9'(SizeAt + SizeFieldBytes)) begin
          o            = octal_step(s.size_st, s.size_value, c);
          s.size_st    = o.st;
          s.size_value = o.val;
        end
        if (off == 9'(TypeAt)) s.type_byte = c;
        if (off < 9'(NameFieldBytes) && {2'd0, s.name_length} == off && c != 8'd0) begin
          s.name_length = s.name_length + 7'd1;
          s.pm          = path_next(s.pm, c);
          if (c == "/") begin
            if (s.comp <= 3'd2) s.unsafe = 1'b1;
            s.comp = 3'd0;
          end else if (c == ".") begin
            if (s.comp < 3'd3) s.comp = s.comp + 3'd1;
          end else begin
            s.comp = 3'd3;
          end
          s.prev_char = c;
        end

        if (off < 9'(BlockBytes - 1)) begin
          s.block_offset = off + 9'd1;
          if (eos) begin
            res[n[0]] = mk_res(KIND_ERROR, ERR_TRUNC_HDR, 8'd0, 36'd0, 1'b0, 1'b0);
            n = n + 2'd1; verdict = 1'b1;
          end
        end else begin
          // judge the completed header, first failing rule wins
          t = s.type_byte;
          if (s.prev_char != "/" && s.comp <= 3'd2) s.unsafe = 1'b1;
          path_ok = (s.pm == PM_META4) || (s.pm == PM_META5) || (s.pm == PM_MANI) ||
                    (s.pm == PM_PAY_END) || (s.pm == PM_PAY_IN) || (s.pm == PM_PAY_ANY) ||
                    (s.pm == PM_MANI_SL);
          if (s.all_zero) begin
            if (eos) begin
              res[n[0]] = mk_res(KIND_ERROR, ERR_NO_END2, 8'd0, 36'd0, 1'b0, 1'b0);
              n = n + 2'd1; verdict = 1'b1;
            end else begin
              s.phase        = PH_END2;
              s.block_offset = '0;
              s.all_zero     = 1'b1;
            end
          end else if (!s.magic_ok) begin
            res[n[0]] = mk_res(KIND_ERROR, ERR_NOT_USTAR, 8'd0, 36'd0, 1'b0, 1'b0);
            n = n + 2'd1; verdict = 1'b1;
          end else if (s.sum_st == OCT_LEAD || s.sum_st == OCT_BAD ||
                       s.stored_sum != {7'd0, s.byte_sum}) begin
            res[n[0]] = mk_res(KIND_ERROR, ERR_CHECKSUM, 8'd0, 36'd0, 1'b0, 1'b0);
            n = n + 2'd1; verdict = 1'b1;
          end else if (s.name_length == 7'd0) begin
            res[n[0]] = mk_res(KIND_ERROR, ERR_EMPTY_NAME, 8'd0, 36'd0, 1'b0, 1'b0);
            n = n + 2'd1; verdict = 1'b1;
          end else if (s.size_st == OCT_LEAD || s.size_st == OCT_BAD) begin
            res[n[0]] = mk_res(KIND_ERROR, ERR_BAD_SIZE, 8'd0, 36'd0, 1'b0, 1'b0);
            n = n + 2'd1; verdict = 1'b1;
          end else if (t == "x" || t == "g" || t == "K" || t == "L" || t == "S") begin
            res[n[0]] = mk_res(KIND_ERROR, ERR_EXTENSION, 8'd0, 36'd0, 1'b0, 1'b0);
            n = n + 2'd1; verdict = 1'b1;
          end else if (!path_ok || s.unsafe) begin
            res[n[0]] = mk_res(KIND_ERROR, ERR_BAD_PATH, 8'd0, 36'd0, 1'b0, 1'b0);
            n = n + 2'd1; verdict = 1'b1;
          end else if (t == "2" || t == "1") begin
            res[n[0]] = mk_res(KIND_ERROR, ERR_LINK, 8'd0, 36'd0, 1'b0, 1'b0);
            n = n + 2'd1; verdict = 1'b1;
          end else if (t != 8'd0 && t != "0" && t != "5") begin
            res[n[0]] = mk_res(KIND_ERROR, ERR_BAD_TYPE, 8'd0, 36'd0, 1'b0, 1'b0);
            n = n + 2'd1; verdict = 1'b1;
          end else if (s.pm == PM_MANI) begin
            if (t == "5") begin
              res[n[0]] = mk_res(KIND_ERROR, ERR_MF_IRREGULAR, 8'd0, 36'd0, 1'b0, 1'b0);
              n = n + 2'd1; verdict = 1'b1;
            end else if (s.manifest_seen) begin
              res[n[0]] = mk_res(KIND_ERROR, ERR_DUPLICATE, 8'd0, 36'd0, 1'b0, 1'b0);
              n = n + 2'd1; verdict = 1'b1;
            end else if (s.size_value == 36'd0 ||
                         s.size_value > {12'd0, max_manifest_bytes}) begin
              res[n[0]] = mk_res(KIND_ERROR, ERR_MF_SIZE, 8'd0, 36'd0, 1'b0, 1'b0);
              n = n + 2'd1; verdict = 1'b1;
            end else begin
              res[n[0]] = mk_res(KIND_MEMBER, ERR_TRUNC_HDR, 8'd0, s.size_value, 1'b0, 1'b1);
              n = n + 2'd1;
              s.manifest_seen = 1'b1;
              s.in_manifest   = 1'b1;
              s.phase         = PH_DATA;
              s.remaining     = s.size_value;
              if (eos) begin
                res[n[0]] = mk_res(KIND_ERROR, ERR_TRUNC_MF, 8'd0, 36'd0, 1'b0, 1'b0);
                n = n + 2'd1; verdict = 1'b1;
              end
            end
          end else begin
            res[n[0]] = mk_res(KIND_MEMBER, ERR_TRUNC_HDR, 8'd0, s.size_value,
                               t == "5", 1'b0);
            n = n + 2'd1;
            if (s.size_value != 36'd0) begin
              s.phase       = PH_DATA;
              s.remaining   = s.size_value;
              s.in_manifest = 1'b0;
              if (eos) begin
                res[n[0]] = mk_res(KIND_ERROR, ERR_TRUNC_MEMBER, 8'd0, 36'd0, 1'b0, 1'b0);
                n = n + 2'd1; verdict = 1'b1;
              end
            end else begin
              do_complete = 1'b1;
            end
          end
        end
      end

      PH_DATA: begin
        mani        = s.in_manifest;
        s.remaining = s.remaining - 36'd1;
        if (mani) begin
          res[n[0]] = mk_res(KIND_MBYTE, ERR_TRUNC_HDR, c, 36'd0, 1'b0, 1'b0);
          n = n + 2'd1;
        end
        if (s.remaining == 36'd0) begin
          pad           = 9'd0 - s.size_value[8:0];
          s.in_manifest = 1'b0;
          if (pad != 9'd0) begin
            s.phase     = PH_PAD;
            s.remaining = {27'd0, pad};
            if (eos) begin
              res[n[0]] = mk_res(KIND_ERROR, ERR_TRUNC_MEMBER, 8'd0, 36'd0, 1'b0, 1'b0);
              n = n + 2'd1; verdict = 1'b1;
            end
          end else begin
            do_complete = 1'b1;
          end
        end else if (eos) begin
          res[n[0]] = mk_res(KIND_ERROR, mani ? ERR_TRUNC_MF : ERR_TRUNC_MEMBER,
                             8'd0, 36'd0, 1'b0, 1'b0);
          n = n + 2'd1; verdict = 1'b1;
        end
      end

      PH_PAD: begin
        s.remaining = s.remaining - 36'd1;
        if (s.remaining == 36'd0) begin
          do_complete = 1'b1;
        end else if (eos) begin
          res[n[0]] = mk_res(KIND_ERROR, ERR_TRUNC_MEMBER, 8'd0, 36'd0, 1'b0, 1'b0);
          n = n + 2'd1; verdict = 1'b1;
        end
      end

      PH_END2: begin
        if (c != 8'd0) s.all_zero = 1'b0;
        if (off < 9'(BlockBytes - 1)) begin
          s.block_offset = off + 9'd1;
          if (eos) begin
            res[n[0]] = mk_res(KIND_ERROR, ERR_NO_END2, 8'd0, 36'd0, 1'b0, 1'b0);
            n = n + 2'd1; verdict = 1'b1;
          end
        end else if (!s.all_zero) begin
          res[n[0]] = mk_res(KIND_ERROR, ERR_NO_END2, 8'd0, 36'd0, 1'b0, 1'b0);
          n = n + 2'd1; verdict = 1'b1;
        end else if (!s.manifest_seen) begin
          res[n[0]] = mk_res(KIND_ERROR, ERR_NO_MANIFEST, 8'd0, 36'd0, 1'b0, 1'b0);
          n = n + 2'd1; verdict = 1'b1;
        end else begin
          res[n[0]] = mk_res(KIND_VALID, ERR_TRUNC_HDR, 8'd0, 36'd0, 1'b0, 1'b0);
          n = n + 2'd1; verdict = 1'b1;
        end
      end

      default: begin
        s = clear_all(st);
      end
    endcase

    // member's data and padding have passed: count it
    if (do_complete) begin
      cnt = {1'b0, s.members_done} + 21'd1;
      if (cnt > {1'b0, max_members}) begin
        res[n[0]] = mk_res(KIND_ERROR, ERR_TOO_MANY, 8'd0, 36'd0, 1'b0, 1'b0);
        n = n + 2'd1; verdict = 1'b1;
      end else begin
        s.members_done = cnt[19:0];
        s = start_header(s);
        if (eos) begin
          res[n[0]] = mk_res(KIND_ERROR, ERR_TRUNC_HDR, 8'd0, 36'd0, 1'b0, 1'b0);
          n = n + 2'd1; verdict = 1'b1;
        end
      end
    end

    if (verdict) begin
      if (eos) s = clear_all(s);
      else     s.phase = PH_DRAIN;
    end

    if (n == 2'd2)      res[1].last_of_run = 1'b1;
    else if (n == 2'd1) res[0].last_of_run = 1'b1;

    st_next = s;
    push.n  = accept ? n : 2'd0;
    push.r0 = res[0];
    push.r1 = res[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= clear_all(st_t'('0));
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

// File: design/uav_fifo.sv
// ----------------------------------------------------------------------------
// uav_fifo
// Result queue: takes up to two results a cycle, gives one beat a cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module uav_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire uav_pkg::push_t push,
  output logic               room,
  output logic               out_valid,
  input  wire logic          out_ready,
  output uav_pkg::res_t      head
);
  import uav_pkg::*;

  res_t                mem [FifoDepth];
  logic [FifoPtrW-1:0] wp;
  logic [FifoPtrW-1:0] rp;
  logic [FifoPtrW:0]   cnt;
  logic [FifoPtrW:0]   cnt_next;
  logic                pop;

  assign out_valid = (cnt != '0);
  assign head      = mem[rp];
  assign pop       = out_valid && out_ready;
  // two free entries so a byte with two results never overflows
  assign room      = (cnt <= (FifoPtrW+1)'(FifoDepth - 2));
  assign cnt_next  = cnt + {{(FifoPtrW-1){1'b0}}, push.n} - {{FifoPtrW{1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wp] <= push.r0;
    if (push.n == 2'd2) mem[wp + FifoPtrW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + FifoPtrW'(push.n);
      rp  <= rp + FifoPtrW'(pop);
      cnt <= cnt_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> (cnt - {{FifoPtrW{1'b0}}, pop} + {{(FifoPtrW-1){1'b0}}, push.n})
                         <= (FifoPtrW+1)'(FifoDepth))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> $past(room) || room)
    else $error("two results pushed without room");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (cnt == '0) && !out_valid)
    else $error("queue not empty after reset");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> push.r1.last_of_run && !push.r0.last_of_run)
    else $error("last_of_run misplaced on a two-result byte");

endmodule

`default_nettype wire

// File: tb/tb_ustar_archive_validator_top.sv
// ----------------------------------------------------------------------------
// tb_ustar_archive_validator_top
// Self-checking bench for the ustar archive validator. Whole archives are
// built here, good and damaged, and streamed in one byte per beat. A local
// model of the validator predicts every result, and each result beat is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ustar_archive_validator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import uav_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int          SettleCycles = 12;   // result queue depth plus margin

  // tar type flags
  localparam logic [7:0] TF_NUL      = 8'h00;
  localparam logic [7:0] TF_REG      = "0";
  localparam logic [7:0] TF_HARD     = "1";
  localparam logic [7:0] TF_SYM      = "2";
  localparam logic [7:0] TF_CHR      = "3";
  localparam logic [7:0] TF_DIR      = "5";
  localparam logic [7:0] TF_CONTIG   = "7";
  localparam logic [7:0] TF_PAX_X    = "x";
  localparam logic [7:0] TF_PAX_G    = "g";
  localparam logic [7:0] TF_LONGLINK = "K";
  localparam logic [7:0] TF_LONGNAME = "L";
  localparam logic [7:0] TF_SPARSE   = "S";

  // header damage
  typedef enum int { HB_NONE, HB_MAGIC, HB_SUM, HB_SIZE } header_blemish_t;

  // archive-level damage
  typedef enum int {
    FL_NONE, FL_MAGIC, FL_SUM, FL_EMPTY_NAME, FL_SIZE, FL_EXT, FL_PATH, FL_LINK,
    FL_TYPE, FL_MF_DIR, FL_DUP_MF, FL_MF_SIZE, FL_CUT, FL_NO_END2, FL_NO_MF,
    FL_TRAILING, FL_NOISE
  } archive_flaw_t;

  // --------------------------------------------------------------------------
  // DUT connections
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [4:0]  error_code;
  logic [7:0]  manifest_byte;
  logic [35:0] member_size;
  logic        member_kind;
  logic        is_manifest;
  logic        last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  ustar_archive_validator_top DUT (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .end_of_stream,
    .out_valid, .out_ready, .out_kind, .error_code, .manifest_byte,
    .member_size, .member_kind, .is_manifest, .last_of_run,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  res_t        expected_results[$];   // predictions waiting for their beat
  res_t        step_results[$];       // results of the byte being modelled
  logic        step_verdict;
  logic [7:0]  arc[$];                // archive under construction
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned bytes_sent = 0;
  int unsigned archives_sent = 0;
  int unsigned verdicts_valid = 0;

  // model copy of the validator
  phase_t      v_phase;
  logic [8:0]  v_off;
  logic [16:0] v_sum;
  logic        v_all_zero, v_magic_ok;
  logic [23:0] v_stored_sum;
  logic [1:0]  v_sum_st;
  logic [35:0] v_size;
  logic [1:0]  v_size_st;
  logic [7:0]  v_type;
  logic [6:0]  v_name_len;
  logic [4:0]  v_pm;
  logic [2:0]  v_comp;
  logic        v_unsafe;
  logic [7:0]  v_prev;
  logic [35:0] v_remaining;
  logic [19:0] v_members;
  logic        v_saw_mf, v_in_mf, v_verdict_given;
  logic [23:0] v_max_manifest = MAX_MANIFEST_RESET;
  logic [19:0] v_max_members  = MAX_MEMBERS_RESET;

  // --------------------------------------------------------------------------
  // Clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random stalls at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [35:0] got,
                                 input logic [35:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat, kind", out_kind, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_kind != want.out_kind)
          report_mismatch("out_kind", out_kind, want.out_kind);
        if (error_code != want.error_code)
          report_mismatch("error_code", error_code, want.error_code);
        if (manifest_byte != want.manifest_byte)
          report_mismatch("manifest_byte", manifest_byte, want.manifest_byte);
        if (member_size != want.member_size)
          report_mismatch("member_size", member_size, want.member_size);
        if (member_kind != want.member_kind)
          report_mismatch("member_kind", member_kind, want.member_kind);
        if (is_manifest != want.is_manifest)
          report_mismatch("is_manifest", is_manifest, want.is_manifest);
        if (last_of_run != want.last_of_run)
          report_mismatch("last_of_run", last_of_run, want.last_of_run);
        if (want.out_kind == KIND_VALID) verdicts_valid++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Validator model
  // --------------------------------------------------------------------------
  function automatic void new_header();
    v_phase = PH_HEADER; v_off = '0; v_sum = '0;
    v_all_zero = 1'b1; v_magic_ok = 1'b1;
    v_stored_sum = '0; v_sum_st = OCT_LEAD;
    v_size = '0; v_size_st = OCT_LEAD;
    v_type = '0; v_name_len = '0; v_pm = PM_START; v_comp = '0;
    v_unsafe = 1'b0; v_prev = '0;
  endfunction

  function automatic void clear_archive();
    new_header();
    v_remaining = '0; v_members = '0;
    v_saw_mf = 1'b0; v_in_mf = 1'b0; v_verdict_given = 1'b0;
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [4:0] err, logic [7:0] mb,
                                     logic [35:0] sz, logic mk, logic im);
    res_t r;
    r.out_kind = kind; r.error_code = err; r.manifest_byte = mb;
    r.member_size = sz; r.member_kind = mk; r.is_manifest = im; r.last_of_run = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void give_error(logic [4:0] code);
    add_result(KIND_ERROR, code, '0, '0, 1'b0, 1'b0);
    step_verdict = 1'b1;
  endfunction

  // one character of an octal number field
  function automatic void octal_feed(inout logic [1:0] st, inout logic [35:0] val,
                                     input logic [7:0] c);
    logic is_digit, is_blank;
    is_digit = (c >= "0") && (c <= "7");
    is_blank = (c == " ") || (c == 8'h00);
    if (st == OCT_LEAD) begin
      if (is_digit) begin
        st = OCT_DIG; val = {33'd0, c[2:0]};
      end else if (!is_blank) begin
        st = OCT_BAD;
      end
    end else if (st == OCT_DIG) begin
      if (is_blank) st = OCT_DONE;
      else if (is_digit) val = {val[32:0], c[2:0]};
      else st = OCT_BAD;
    end
  endfunction

  // prefix tracker for META/manifest and payload/
  function automatic logic [4:0] path_step(logic [4:0] s, logic [7:0] c);
    string meta_txt, pay_txt;
    meta_txt = "META/manifest";
    pay_txt  = "payload/";
    if (s == PM_START) return (c == "M") ? PM_META : ((c == "p") ? PM_PAY : PM_DEAD);
    if (s >= PM_META && s < PM_MANI) return (c == meta_txt[s]) ? s + 5'd1 : PM_DEAD;
    if (s == PM_MANI) return (c == "/") ? PM_MANI_SL : PM_DEAD;
    if (s >= PM_PAY && s <= PM_PAY_END) return (c == pay_txt[s - 13]) ? s + 5'd1 : PM_DEAD;
    if (s == PM_PAY_IN || s == PM_PAY_ANY) return PM_PAY_ANY;
    return PM_DEAD;
  endfunction

  function automatic void header_char(logic [7:0] c);
    string       magic_txt;
    logic [35:0] wide;
    magic_txt = "ustar";
    if (c != 0) v_all_zero = 1'b0;
    v_sum = v_sum + ((v_off >= SumAt && v_off < SumEnd) ? 17'd32 : {9'd0, c});
    if (v_off >= MagicAt && v_off < MagicAt + 5) begin
      if (c != magic_txt[v_off - MagicAt]) v_magic_ok = 1'b0;
    end else if (v_off == MagicAt + 5 && c != 0) begin
      v_magic_ok = 1'b0;
    end
    if (v_off >= SumAt && v_off < SumEnd) begin
      wide = {12'd0, v_stored_sum};
      octal_feed(v_sum_st, wide, c);
      v_stored_sum = wide[23:0];
    end
    if (v_off >= SizeAt && v_off < SizeAt + SizeFieldBytes) octal_feed(v_size_st, v_size, c);
    if (v_off == TypeAt) v_type = c;
    if (v_off < NameFieldBytes && v_name_len == v_off && c != 0) begin
      v_name_len++;
      v_pm = path_step(v_pm, c);
      if (c == "/") begin
        if (v_comp <= 2) v_unsafe = 1'b1;   // empty, "." or ".." component
        v_comp = 0;
      end else if (c == ".") begin
        if (v_comp < 3) v_comp++;
      end else begin
        v_comp = 3;
      end
      v_prev = c;
    end
  endfunction

  function automatic void member_done(logic eos);
    logic [20:0] cnt;
    cnt = {1'b0, v_members} + 21'd1;
    if (cnt > {1'b0, v_max_members}) begin
      give_error(ERR_TOO_MANY);
      return;
    end
    v_members = cnt[19:0];
    new_header();
    if (eos) give_error(ERR_TRUNC_HDR);
  endfunction

  function automatic void judge_header(logic eos);
    logic path_ok;
    if (v_all_zero) begin
      if (eos) begin
        give_error(ERR_NO_END2);
        return;
      end
      v_phase = PH_END2; v_off = '0; v_all_zero = 1'b1;
      return;
    end
    if (!v_magic_ok) begin give_error(ERR_NOT_USTAR); return; end
    if (v_sum_st == OCT_LEAD || v_sum_st == OCT_BAD || v_stored_sum != {7'd0, v_sum}) begin
      give_error(ERR_CHECKSUM); return;
    end
    if (v_name_len == 0) begin give_error(ERR_EMPTY_NAME); return; end
    if (v_size_st == OCT_LEAD || v_size_st == OCT_BAD) begin give_error(ERR_BAD_SIZE); return; end
    if (v_type inside {TF_PAX_X, TF_PAX_G, TF_LONGLINK, TF_LONGNAME, TF_SPARSE}) begin
      give_error(ERR_EXTENSION); return;
    end
    if (v_prev != "/" && v_comp <= 2) v_unsafe = 1'b1;
    path_ok = v_pm inside {PM_META4, PM_META5, PM_MANI, PM_PAY_END, PM_PAY_IN, PM_PAY_ANY,
                           PM_MANI_SL};
    if (!path_ok || v_unsafe) begin give_error(ERR_BAD_PATH); return; end
    if (v_type == TF_HARD || v_type == TF_SYM) begin give_error(ERR_LINK); return; end
    if (!(v_type inside {TF_NUL, TF_REG, TF_DIR})) begin give_error(ERR_BAD_TYPE); return; end
    if (v_pm == PM_MANI) begin
      if (v_type == TF_DIR) begin give_error(ERR_MF_IRREGULAR); return; end
      if (v_saw_mf) begin give_error(ERR_DUPLICATE); return; end
      if (v_size == 0 || v_size > {12'd0, v_max_manifest}) begin
        give_error(ERR_MF_SIZE); return;
      end
      add_result(KIND_MEMBER, '0, '0, v_size, 1'b0, 1'b1);
      v_saw_mf = 1'b1; v_in_mf = 1'b1;
      v_phase = PH_DATA; v_remaining = v_size;
      if (eos) give_error(ERR_TRUNC_MF);
      return;
    end
    add_result(KIND_MEMBER, '0, '0, v_size, v_type == TF_DIR, 1'b0);
    if (v_size != 0) begin
      v_phase = PH_DATA; v_remaining = v_size; v_in_mf = 1'b0;
      if (eos) give_error(ERR_TRUNC_MEMBER);
    end else begin
      member_done(eos);
    end
  endfunction

  // work out the results of one accepted archive byte
  function automatic void predict_byte(logic [7:0] c, logic eos);
    logic       was_mf;
    logic [8:0] pad;
    step_results.delete();
    step_verdict = 1'b0;
    if (v_phase == PH_DRAIN || v_verdict_given) begin
      if (eos) clear_archive();
      return;
    end
    case (v_phase)
      PH_HEADER: begin
        header_char(c);
        if (v_off < BlockBytes - 1) begin
          v_off++;
          if (eos) give_error(ERR_TRUNC_HDR);
        end else begin
          judge_header(eos);
        end
      end
      PH_DATA: begin
        was_mf = v_in_mf;
        v_remaining = v_remaining - 36'd1;
        if (was_mf) add_result(KIND_MBYTE, '0, c, '0, 1'b0, 1'b0);
        if (v_remaining == 0) begin
          pad = (v_size[8:0] == 0) ? 9'd0 : 9'd0 - v_size[8:0];
          v_in_mf = 1'b0;
          if (pad != 0) begin
            v_phase = PH_PAD; v_remaining = {27'd0, pad};
            if (eos) give_error(ERR_TRUNC_MEMBER);
          end else begin
            member_done(eos);
          end
        end else if (eos) begin
          give_error(was_mf ? ERR_TRUNC_MF : ERR_TRUNC_MEMBER);
        end
      end
      PH_PAD: begin
        v_remaining = v_remaining - 36'd1;
        if (v_remaining == 0) member_done(eos);
        else if (eos) give_error(ERR_TRUNC_MEMBER);
      end
      default: begin   // second end block
        if (c != 0) v_all_zero = 1'b0;
        if (v_off < BlockBytes - 1) begin
          v_off++;
          if (eos) give_error(ERR_NO_END2);
        end else if (!v_all_zero) begin
          give_error(ERR_NO_END2);
        end else if (!v_saw_mf) begin
          give_error(ERR_NO_MANIFEST);
        end else begin
          add_result(KIND_VALID, '0, '0, '0, 1'b0, 1'b0);
          step_verdict = 1'b1;
        end
      end
    endcase
    if (step_verdict) begin
      if (eos) clear_archive();
      else begin
        v_phase = PH_DRAIN; v_verdict_given = 1'b1;
      end
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last_of_run = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  // valid is only lowered in an idle cycle, so back-to-back beats keep it high
  task automatic send_byte(input logic [7:0] c, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= c;
    end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    predict_byte(c, eos);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MAX_MANIFEST) v_max_manifest = value;
    else if (idx == CFG_MAX_MEMBERS) v_max_members = value[19:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stream the built archive; optionally hold off mid-way until drained
  task automatic send_archive(input bit hold_off);
    int hold_at;
    hold_at = hold_off ? $urandom_range(0, arc.size() - 1) : -1;
    foreach (arc[i]) begin
      if (i == hold_at) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      send_byte(arc[i], i == arc.size() - 1);
    end
    archives_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Archive construction
  // --------------------------------------------------------------------------
  task automatic add_header(input string name, input longint unsigned size,
                            input logic [7:0] tflag, input header_blemish_t blemish);
    logic [7:0]  h[BlockBytes];
    int unsigned chk;
    string       mode_txt, magic_txt;
    mode_txt  = "0000644";
    magic_txt = "ustar";
    foreach (h[i]) h[i] = 8'h00;
    for (int i = 0; i < name.len() && i < NameFieldBytes; i++) h[i] = name[i];
    for (int i = 0; i < 7; i++) h[100 + i] = mode_txt[i];
    for (int k = 0; k < 11; k++) h[SizeAt + k] = "0" + ((size >> (3 * (10 - k))) & 7);
    if (blemish == HB_SIZE) h[SizeAt + $urandom_range(0, 10)] = "9";
    h[TypeAt] = tflag;
    for (int i = 0; i < 5; i++) h[MagicAt + i] = magic_txt[i];
    if (blemish == HB_MAGIC) h[MagicAt + $urandom_range(0, 5)] = "X";
    h[MagicAt + 6] = "0";
    h[MagicAt + 7] = "0";
    chk = 0;
    foreach (h[i]) chk += (i >= SumAt && i < SumEnd) ? 32 : h[i];
    if (blemish == HB_SUM) chk += $urandom_range(1, 7);
    for (int k = 0; k < 6; k++) h[SumAt + k] = "0" + ((chk >> (3 * (5 - k))) & 7);
    h[SumAt + 6] = 8'h00;
    h[SumAt + 7] = " ";
    foreach (h[i]) arc.push_back(h[i]);
  endtask

  // member body plus zero padding to the block boundary
  task automatic add_body(input int unsigned size);
    repeat (size) arc.push_back($urandom_range(0, 255));
    if (size % BlockBytes != 0) repeat (BlockBytes - size % BlockBytes) arc.push_back(8'h00);
  endtask

  task automatic add_zero_block();
    repeat (BlockBytes) arc.push_back(8'h00);
  endtask

  task automatic add_manifest();
    int unsigned size;
    size = $urandom_range(1, (v_max_manifest < 40) ? v_max_manifest : 40);
    add_header("META/manifest", size, $urandom_range(0, 1) ? TF_REG : TF_NUL, HB_NONE);
    add_body(size);
  endtask

  task automatic add_plain_member();
    int unsigned size;
    string       name;
    case ($urandom_range(0, 7))
      0: begin add_header("payload/", 0, TF_DIR, HB_NONE); return; end
      1: begin add_header("META/", 0, TF_DIR, HB_NONE); return; end
      2: begin add_header($sformatf("payload/d%0d/", $urandom_range(0, 99)), 0, TF_DIR,
                          HB_NONE); return; end
      3: begin   // directory that still carries data
        size = $urandom_range(1, 20);
        add_header("payload", size, TF_DIR, HB_NONE);
        add_body(size);
        return;
      end
      4: name = "META/manifest/x";
      5: name = "META";
      default: name = $sformatf("payload/f%0d.bin", $urandom_range(0, 999));
    endcase
    case ($urandom_range(0, 5))
      0: size = 0;
      1: size = BlockBytes * $urandom_range(1, 2);
      default: size = $urandom_range(1, 700);
    endcase
    add_header(name, size, $urandom_range(0, 3) ? TF_REG : TF_NUL, HB_NONE);
    add_body(size);
  endtask

  task automatic add_flawed_header(input archive_flaw_t flaw);
    logic [7:0] tf;
    string      name;
    case (flaw)
      FL_MAGIC:      add_header("payload/a", 0, TF_REG, HB_MAGIC);
      FL_SUM:        add_header("payload/a", 0, TF_REG, HB_SUM);
      FL_SIZE:       add_header("payload/a", 0, TF_REG, HB_SIZE);
      FL_EMPTY_NAME: add_header("", 0, TF_REG, HB_NONE);
      FL_EXT: begin
        case ($urandom_range(0, 4))
          0: tf = TF_PAX_X;
          1: tf = TF_PAX_G;
          2: tf = TF_LONGLINK;
          3: tf = TF_LONGNAME;
          default: tf = TF_SPARSE;
        endcase
        add_header("payload/a", 0, tf, HB_NONE);
      end
      FL_PATH: begin
        case ($urandom_range(0, 6))
          0: name = "../etc/passwd";
          1: name = "payload/../x";
          2: name = "other/file";
          3: name = "payload/.";
          4: name = "payload//a";
          5: name = "META/manifes";
          default: name = "payload/..";
        endcase
        add_header(name, 0, TF_REG, HB_NONE);
      end
      FL_LINK:   add_header("payload/l", 0, $urandom_range(0, 1) ? TF_HARD : TF_SYM, HB_NONE);
      FL_TYPE:   add_header("payload/t", 0, $urandom_range(0, 1) ? TF_CHR : TF_CONTIG, HB_NONE);
      FL_MF_DIR: add_header("META/manifest", 0, TF_DIR, HB_NONE);
      FL_MF_SIZE: add_header("META/manifest",
                             $urandom_range(0, 1) ? 0 : longint'(v_max_manifest) + 1,
                             TF_REG, HB_NONE);
      default: ;
    endcase
  endtask

  task automatic build_archive(input archive_flaw_t flaw, input int max_plain);
    int n_plain, mf_at, flaw_at, cut;
    arc.delete();
    if (flaw == FL_NOISE) begin
      repeat ($urandom_range(1, 700)) arc.push_back($urandom_range(0, 255));
      return;
    end
    n_plain = $urandom_range(0, max_plain);
    mf_at   = $urandom_range(0, n_plain);
    flaw_at = $urandom_range(0, n_plain);
    for (int i = 0; i <= n_plain; i++) begin
      if (i == mf_at && flaw != FL_NO_MF) add_manifest();
      if (i == flaw_at) add_flawed_header(flaw);
      if (i < n_plain) add_plain_member();
    end
    if (flaw == FL_DUP_MF) add_manifest();
    add_zero_block();
    add_zero_block();
    if (flaw == FL_NO_END2) arc[arc.size() - 1 - $urandom_range(0, BlockBytes - 1)] =
        $urandom_range(1, 255);
    if (flaw == FL_TRAILING) repeat ($urandom_range(1, 60)) arc.push_back($urandom_range(0, 255));
    if (flaw == FL_CUT) begin
      cut = $urandom_range(1, arc.size() - 1);
      while (arc.size() > cut) void'(arc.pop_back());
    end
  endtask

  function automatic archive_flaw_t pick_flaw();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return FL_NONE;
    if (roll < 60) return FL_CUT;
    if (roll < 66) return FL_TRAILING;
    return archive_flaw_t'($urandom_range(FL_MAGIC, FL_NOISE));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // one archive for every kind of damage, plus the plain good case
  task automatic test_each_flaw();
    for (int f = FL_NONE; f <= FL_NOISE; f++) begin
      build_archive(archive_flaw_t'(f), 2);
      send_archive(1'b0);
    end
    // random cut points, which may land in a header, manifest data or the end blocks
    repeat (6) begin
      build_archive(FL_CUT, 1);
      send_archive(1'b0);
    end
  endtask

  // register extremes: tiny and full-range limits
  task automatic test_limits();
    wait_idle();
    cfg_write(CFG_MAX_MEMBERS, 24'd1);
    cfg_write(CFG_MAX_MANIFEST, 24'd1);
    repeat (4) begin
      build_archive(FL_NONE, 2);        // a second member, if one is built, trips the member limit
      send_archive(1'b0);
    end
    build_archive(FL_MF_SIZE, 0);
    send_archive(1'b0);
    wait_idle();
    cfg_write(CFG_MAX_MEMBERS, 24'hFFFFF);
    cfg_write(CFG_MAX_MANIFEST, 24'hFFFFFF);
    repeat (3) begin
      build_archive(FL_MF_SIZE, 1);     // size zero or just above the 24-bit limit
      send_archive(1'b0);
    end
    build_archive(FL_NONE, 3);
    send_archive(1'b0);
    wait_idle();
    cfg_write(CFG_MAX_MEMBERS, 24'd3);
    cfg_write(CFG_MAX_MANIFEST, 24'd20);
    repeat (4) begin
      build_archive(FL_NONE, 3);
      send_archive(1'b0);
    end
    wait_idle();
    cfg_write(CFG_MAX_MEMBERS, {4'd0, MAX_MEMBERS_RESET});
    cfg_write(CFG_MAX_MANIFEST, MAX_MANIFEST_RESET);
  endtask

  // random archives under one pair of sender idle and receiver stall rates
  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      build_archive(pick_flaw(), 3);
      send_archive($urandom_range(0, 7) == 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_archive();
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_each_flaw();
    test_limits();
    test_random_phase(0, 0, 14);
    test_random_phase(48, 0, 14);
    test_random_phase(0, 48, 14);
    test_random_phase(8, 8, 14);
    send_idle_pct = 0;
    recv_stall_pct = 0;

    // let everything drain and settle, then wait SettleCycles more for stray beats
    wait_idle();
    repeat (SettleCycles) @(posedge clk);

    $display("covered %0d archives, %0d bytes, %0d result beats checked, %0d valid verdicts",
             archives_sent, bytes_sent, results_checked, verdicts_valid);
    $display("all header errors, truncations, limits and four idle/stall mixes exercised");
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatch_count,
               expected_results.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
